@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// PPM P6 stream parser package
// Shared constants, result codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

	// Default parameter values.
	localparam int DIM_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;

	// Result kinds.
	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_PIX = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_MAGIC   = 3'd1;
	localparam logic [2:0] ERR_NONDIG  = 3'd2;
	localparam logic [2:0] ERR_LARGE   = 3'd3;
	localparam logic [2:0] ERR_ZEROMAX = 3'd4;
	localparam logic [2:0] ERR_SAMPLE  = 3'd5;

	// Characters of the file format.
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Largest max value and largest one-byte sample.
	localparam logic [15:0] MAX_LIMIT = 16'd65535;
	localparam logic [15:0] BYTE_MAX  = 16'd255;

	// One classified item passed from front to back.
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  code;
		logic        last;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] smax;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} entry_t;

endpackage

`default_nettype wire

@@ src/pps_front.sv @@
// ----------------------------------------------------------------------------
// PPM P6 front end
// Takes one byte per cycle while take is high, parses the header and gathers
// pixel samples, and pushes header, pixel and error items into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_front #(
	parameter int DIM_BITS = pps_pkg::DIM_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               take,
	input  wire  [7:0]        data_byte,
	output logic              push,
	output pps_pkg::entry_t   entry
);

	localparam logic [2:0] PH_MAGIC0 = 3'd0;
	localparam logic [2:0] PH_MAGIC1 = 3'd1;
	localparam logic [2:0] PH_WIDTH  = 3'd2;
	localparam logic [2:0] PH_HEIGHT = 3'd3;
	localparam logic [2:0] PH_MAX    = 3'd4;
	localparam logic [2:0] PH_PIXELS = 3'd5;

	localparam logic [19:0] DIM_LIMIT = 20'((64'd1 << DIM_BITS) - 64'd1);

	logic [2:0]  phase_q;
	logic        p_ok_q;
	logic        in_token_q;
	logic [15:0] accum_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [15:0] max_q;
	logic [31:0] pix_left_q;
	logic [2:0]  bidx_q;
	logic [7:0]  smp_q [5];

	logic        is_space;
	logic        is_digit;
	logic [19:0] next_acc;
	logic [19:0] limit;
	logic        wide;
	logic        last_byte;
	logic [15:0] r_v;
	logic [15:0] g_v;
	logic [15:0] b_v;
	logic        over;

	// Byte classes and the decimal accumulator.
	assign is_space = (data_byte == pps_pkg::CH_SPACE) || (data_byte == pps_pkg::CH_TAB) ||
	                  (data_byte == pps_pkg::CH_CR) || (data_byte == pps_pkg::CH_LF);
	assign is_digit = (data_byte >= pps_pkg::CH_0) && (data_byte <= pps_pkg::CH_9);
	assign next_acc = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
	                + {16'd0, 4'(data_byte - pps_pkg::CH_0)};
	assign limit    = (phase_q == PH_MAX) ? {4'd0, pps_pkg::MAX_LIMIT} : DIM_LIMIT;

	// Sample assembly for the last byte of a pixel.
	assign wide      = max_q > pps_pkg::BYTE_MAX;
	assign last_byte = wide ? (bidx_q == 3'd5) : (bidx_q == 3'd2);
	assign r_v = wide ? {smp_q[0], smp_q[1]} : {8'd0, smp_q[0]};
	assign g_v = wide ? {smp_q[2], smp_q[3]} : {8'd0, smp_q[1]};
	assign b_v = wide ? {smp_q[4], data_byte} : {8'd0, data_byte};
	assign over = (r_v > max_q) || (g_v > max_q) || (b_v > max_q);

	// Item produced by the current byte.
	always_comb begin
		push  = 1'b0;
		entry = '0;
		if (take) begin
			unique case (phase_q)
				PH_MAGIC1: begin
					if (!(p_ok_q && data_byte == pps_pkg::CH_6)) begin
						push       = 1'b1;
						entry.kind = pps_pkg::KIND_ERR;
						entry.code = pps_pkg::ERR_MAGIC;
						entry.last = 1'b1;
					end
				end
				PH_WIDTH, PH_HEIGHT, PH_MAX: begin
					if (is_space) begin
						if (in_token_q && phase_q == PH_MAX) begin
							push = 1'b1;
							if (accum_q == 16'd0) begin
								entry.kind = pps_pkg::KIND_ERR;
								entry.code = pps_pkg::ERR_ZEROMAX;
								entry.last = 1'b1;
							end else begin
								entry.kind   = pps_pkg::KIND_HDR;
								entry.width  = width_q;
								entry.height = height_q;
								entry.smax   = accum_q;
								entry.last   = (width_q == 16'd0) || (height_q == 16'd0);
							end
						end
					end else if (!is_digit || next_acc > limit) begin
						push       = 1'b1;
						entry.kind = pps_pkg::KIND_ERR;
						entry.code = is_digit ? pps_pkg::ERR_LARGE : pps_pkg::ERR_NONDIG;
						entry.last = 1'b1;
					end
				end
				PH_PIXELS: begin
					if (last_byte) begin
						push = 1'b1;
						if (over) begin
							entry.kind = pps_pkg::KIND_ERR;
							entry.code = pps_pkg::ERR_SAMPLE;
							entry.last = 1'b1;
						end else begin
							entry.kind  = pps_pkg::KIND_PIX;
							entry.smax  = max_q;
							entry.red   = r_v;
							entry.green = g_v;
							entry.blue  = b_v;
							entry.last  = (pix_left_q == 32'd1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAGIC0;
			p_ok_q     <= 1'b0;
			in_token_q <= 1'b0;
			accum_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			max_q      <= '0;
			pix_left_q <= '0;
			bidx_q     <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_MAGIC1: begin
					p_ok_q <= 1'b0;
					if (p_ok_q && data_byte == pps_pkg::CH_6) begin
						phase_q    <= PH_WIDTH;
						in_token_q <= 1'b0;
						accum_q    <= '0;
					end else begin
						phase_q <= PH_MAGIC0;
					end
				end
				PH_WIDTH, PH_HEIGHT, PH_MAX: begin
					if (is_space) begin
						if (in_token_q) begin
							in_token_q <= 1'b0;
							accum_q    <= '0;
							bidx_q     <= '0;
							if (phase_q == PH_WIDTH) begin
								width_q <= accum_q;
								phase_q <= PH_HEIGHT;
							end else if (phase_q == PH_HEIGHT) begin
								height_q <= accum_q;
								phase_q  <= PH_MAX;
							end else begin
								max_q      <= accum_q;
								pix_left_q <= width_q * height_q;
								if (accum_q == 16'd0 || width_q == 16'd0 || height_q == 16'd0)
									phase_q <= PH_MAGIC0;
								else
									phase_q <= PH_PIXELS;
							end
						end
					end else if (!is_digit || next_acc > limit) begin
						phase_q    <= PH_MAGIC0;
						in_token_q <= 1'b0;
						accum_q    <= '0;
						pix_left_q <= '0;
					end else begin
						in_token_q <= 1'b1;
						accum_q    <= next_acc[15:0];
					end
				end
				PH_PIXELS: begin
					if (last_byte) begin
						bidx_q <= '0;
						if (over) begin
							phase_q    <= PH_MAGIC0;
							pix_left_q <= '0;
						end else begin
							pix_left_q <= pix_left_q - 32'd1;
							if (pix_left_q == 32'd1)
								phase_q <= PH_MAGIC0;
						end
					end else begin
						bidx_q <= bidx_q + 3'd1;
					end
				end
				default: begin
					p_ok_q  <= (data_byte == pps_pkg::CH_P);
					phase_q <= PH_MAGIC1;
				end
			endcase
		end
	end

	// Sample byte store, written at the running byte index.
	always_ff @(posedge clk) begin
		if (take && phase_q == PH_PIXELS && !last_byte && bidx_q < 3'd5)
			smp_q[bidx_q] <= data_byte;
	end

endmodule

`default_nettype wire

@@ src/pps_queue.sv @@
// ----------------------------------------------------------------------------
// PPM P6 item queue
// Small first-in first-out store between the parser and the normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  pps_pkg::entry_t   wr_entry,
	input  wire               pop,
	output pps_pkg::entry_t   head,
	output logic              not_empty,
	output logic              full
);

	localparam int AW = $clog2(pps_pkg::QDEPTH);

	pps_pkg::entry_t mem_q [pps_pkg::QDEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [AW:0]     count_q;

	assign head      = mem_q[rptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == (AW+1)'(pps_pkg::QDEPTH);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr_entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Queue integrity.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(pps_pkg::QDEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ src/pps_back.sv @@
// ----------------------------------------------------------------------------
// PPM P6 back end
// Normalizes pixel samples with a shared bit-serial divider and drives the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_back #(
	parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  pps_pkg::entry_t   head,
	input  wire               not_empty,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [1:0]        kind,
	output logic [15:0]       image_width,
	output logic [15:0]       image_height,
	output logic [15:0]       sample_max,
	output logic [16:0]       red_norm,
	output logic [16:0]       green_norm,
	output logic [16:0]       blue_norm,
	output logic [2:0]        error_code,
	output logic              image_end
);

	localparam int NW = 16 + FRAC_BITS;
	localparam int CW = $clog2(NW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]    state_q;
	logic [15:0]   smp_q [3];
	logic [15:0]   div_q;
	logic          last_q;
	logic [1:0]    sel_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [15:0]   rem_q;
	logic [16:0]   quo_q;
	logic [16:0]   res_q [3];

	logic          out_free;
	logic          direct;
	logic          start_pix;
	logic          finish;
	logic [16:0]   trial;
	logic          ge;
	logic [16:0]   trial_sub;
	logic [16:0]   quo_next;

	assign out_free  = !out_valid || out_ready;
	assign direct    = (state_q == ST_IDLE) && not_empty && head.kind != pps_pkg::KIND_PIX
	                   && out_free;
	assign start_pix = (state_q == ST_IDLE) && not_empty && head.kind == pps_pkg::KIND_PIX;
	assign pop       = direct || start_pix;
	assign finish    = (state_q == ST_HOLD) && out_free;

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	assign trial     = {rem_q, dvd_q[NW-1]};
	assign ge        = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};
	assign quo_next  = {quo_q[15:0], ge};

	// Divider sequencing over the three samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_pix) begin
						state_q <= ST_DIV;
						sel_q   <= '0;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == CW'(NW - 1)) begin
						cnt_q <= '0;
						if (sel_q == 2'd2)
							state_q <= ST_HOLD;
						else
							sel_q <= sel_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (start_pix) begin
			smp_q[0] <= head.red;
			smp_q[1] <= head.green;
			smp_q[2] <= head.blue;
			div_q    <= head.smax;
			last_q   <= head.last;
			dvd_q    <= {head.red, {FRAC_BITS{1'b0}}};
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (state_q == ST_DIV) begin
			if (cnt_q == CW'(NW - 1)) begin
				res_q[sel_q] <= quo_next;
				if (sel_q != 2'd2)
					dvd_q <= {smp_q[sel_q + 2'd1], {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				dvd_q <= dvd_q << 1;
				rem_q <= ge ? trial_sub[15:0] : trial[15:0];
				quo_q <= quo_next;
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (direct || finish)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (direct) begin
			kind         <= head.kind;
			image_width  <= head.width;
			image_height <= head.height;
			sample_max   <= head.smax;
			red_norm     <= '0;
			green_norm   <= '0;
			blue_norm    <= '0;
			error_code   <= head.code;
			image_end    <= head.last;
		end else if (finish) begin
			kind         <= pps_pkg::KIND_PIX;
			image_width  <= '0;
			image_height <= '0;
			sample_max   <= '0;
			red_norm     <= res_q[0];
			green_norm   <= res_q[1];
			blue_norm    <= res_q[2];
			error_code   <= pps_pkg::ERR_NONE;
			image_end    <= last_q;
		end
	end

	// Back end consistency.
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == pps_pkg::KIND_ERR |-> image_end) else $error("error without end");
	a_pix_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == pps_pkg::KIND_PIX |-> error_code == pps_pkg::ERR_NONE)
		else $error("pixel with error code");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_q != 16'd0) else $error("division by zero max");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !pop) else $error("queue popped while busy");

endmodule

`default_nettype wire

@@ src/ppm_p6_stream_parser.sv @@
// ----------------------------------------------------------------------------
// PPM P6 stream parser
// Parses a binary PPM byte stream and returns the header and normalized pixels.
//
//   Channel  Handshake            Payload
//   input    in_valid/in_ready    data_byte
//   output   out_valid/out_ready  kind, image_width, image_height, sample_max,
//                                 red_norm, green_norm, blue_norm, error_code,
//                                 image_end
//
// The front takes one word per cycle while the item queue has room.
// A pixel is started from the idle state, runs through the bit-serial divider
// one sample after another and then loads the result register; header and
// error results go straight into the result register.
// Reset clears the parser phase, counters, queue pointers and output valid.
// A stalled output holds the result; the divider waits and the queue fills,
// and input ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_stream_parser #(
	parameter int DIM_BITS  = pps_pkg::DIM_BITS_DEF,
	parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [15:0] sample_max,
	output logic [16:0] red_norm,
	output logic [16:0] green_norm,
	output logic [16:0] blue_norm,
	output logic [2:0]  error_code,
	output logic        image_end
);

	pps_pkg::entry_t f_entry;
	pps_pkg::entry_t q_head;
	logic            f_push;
	logic            q_pop;
	logic            q_not_empty;
	logic            q_full;

	// Input word accepted whenever the queue can take a possible item.
	assign in_ready = !q_full;

	pps_front #(
		.DIM_BITS (DIM_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_valid && in_ready),
		.data_byte (data_byte),
		.push      (f_push),
		.entry     (f_entry)
	);

	pps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.wr_entry  (f_entry),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	pps_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.not_empty    (q_not_empty),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.image_width  (image_width),
		.image_height (image_height),
		.sample_max   (sample_max),
		.red_norm     (red_norm),
		.green_norm   (green_norm),
		.blue_norm    (blue_norm),
		.error_code   (error_code),
		.image_end    (image_end)
	);

endmodule

`default_nettype wire

@@ tb/ppm_checker.sv @@
// ----------------------------------------------------------------------------
// PPM P6 parser result checker
// Watches both channels, predicts each result from the accepted input words
// and compares every accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_checker
	import pps_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [1:0]  kind,
	input  wire  [15:0] image_width,
	input  wire  [15:0] image_height,
	input  wire  [15:0] sample_max,
	input  wire  [16:0] red_norm,
	input  wire  [16:0] green_norm,
	input  wire  [16:0] blue_norm,
	input  wire  [2:0]  error_code,
	input  wire         image_end,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] smax;
		logic [16:0] red;
		logic [16:0] green;
		logic [16:0] blue;
		logic [2:0]  code;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		P_MAGIC0, P_MAGIC1, P_WIDTH, P_HEIGHT, P_MAX, P_PIXELS
	} parse_phase_t;

	parse_phase_t phase;
	logic         in_field;
	logic [19:0]  accum;
	logic [15:0]  width_q, height_q, max_q;
	logic [31:0]  pixels_left;
	logic [2:0]   byte_idx;
	logic [7:0]   held [0:4];
	logic         saw_p;

	result_t due_results [$];

	assign pending = due_results.size();

	// Normalize one sample against the parsed max.
	function automatic logic [16:0] scale_sample(input logic [15:0] v);
		logic [47:0] q;
		if (max_q == 0) return '0;
		q = ({32'd0, v} << 16) / max_q;
		return q[16:0];
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	task automatic raise_error(input logic [2:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERR;
		r.code = code;
		r.last = 1'b1;
		due_results.push_back(r);
		phase = P_MAGIC0;
		in_field = 0;
		accum = 0;
		byte_idx = 0;
		pixels_left = 0;
	endtask

	// Advance the parser by one accepted input word.
	task automatic parse_word(input logic [7:0] b);
		result_t     r;
		logic [15:0] rs, gs, bs;
		int          total;
		r = '0;
		case (phase)
		P_MAGIC1: begin
			if (!(saw_p && b == CH_6)) begin
				raise_error(ERR_MAGIC);
			end else begin
				phase = P_WIDTH;
				in_field = 0;
				accum = 0;
			end
		end
		P_WIDTH, P_HEIGHT, P_MAX: begin
			if (is_blank(b)) begin
				if (in_field) begin
					in_field = 0;
					if (phase == P_WIDTH) begin
						width_q = accum[15:0];
						phase = P_HEIGHT;
						accum = 0;
					end else if (phase == P_HEIGHT) begin
						height_q = accum[15:0];
						phase = P_MAX;
						accum = 0;
					end else begin
						max_q = accum[15:0];
						accum = 0;
						if (max_q == 0) begin
							raise_error(ERR_ZEROMAX);
						end else begin
							pixels_left = width_q * height_q;
							r.kind = KIND_HDR;
							r.width = width_q;
							r.height = height_q;
							r.smax = max_q;
							byte_idx = 0;
							if (pixels_left == 0) begin
								r.last = 1'b1;
								phase = P_MAGIC0;
							end else begin
								phase = P_PIXELS;
							end
							due_results.push_back(r);
						end
					end
				end
			end else if (b < CH_0 || b > CH_9) begin
				raise_error(ERR_NONDIG);
			end else begin
				in_field = 1;
				accum = accum * 10 + (b - CH_0);
				if (accum > MAX_LIMIT) raise_error(ERR_LARGE);
			end
		end
		P_PIXELS: begin
			total = (max_q <= BYTE_MAX) ? 3 : 6;
			if (byte_idx + 1 < total) begin
				held[byte_idx] = b;
				byte_idx++;
			end else begin
				if (total == 3) begin
					rs = held[0];
					gs = held[1];
					bs = b;
				end else begin
					rs = {held[0], held[1]};
					gs = {held[2], held[3]};
					bs = {held[4], b};
				end
				byte_idx = 0;
				if (rs > max_q || gs > max_q || bs > max_q) begin
					raise_error(ERR_SAMPLE);
				end else begin
					r.kind = KIND_PIX;
					r.red = scale_sample(rs);
					r.green = scale_sample(gs);
					r.blue = scale_sample(bs);
					pixels_left--;
					if (pixels_left == 0) begin
						r.last = 1'b1;
						phase = P_MAGIC0;
					end
					due_results.push_back(r);
				end
			end
		end
		default: begin
			saw_p = (b == CH_P);
			phase = P_MAGIC1;
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [16:0] exp_v,
			input logic [16:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Input side first, so a result caused by the same edge is already due.
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			phase = P_MAGIC0;
			in_field = 0;
			accum = 0;
			width_q = 0;
			height_q = 0;
			max_q = 0;
			pixels_left = 0;
			byte_idx = 0;
			saw_p = 0;
			fail_count = 0;
			due_results.delete();
		end else begin
			if (in_valid && in_ready) parse_word(data_byte);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result word, kind %0d", kind);
					fail_count++;
				end else begin
					e = due_results.pop_front();
					check_field("kind", e.kind, kind);
					check_field("image_width", e.width, image_width);
					check_field("image_height", e.height, image_height);
					check_field("sample_max", e.smax, sample_max);
					check_field("red_norm", e.red, red_norm);
					check_field("green_norm", e.green, green_norm);
					check_field("blue_norm", e.blue, blue_norm);
					check_field("error_code", e.code, error_code);
					check_field("image_end", e.last, image_end);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// PPM P6 parser testbench
// Feeds directed and random PPM streams, valid and broken, with random gaps
// on both channels, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import pps_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [7:0]  data_byte = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  kind;
	logic [15:0] image_width, image_height, sample_max;
	logic [16:0] red_norm, green_norm, blue_norm;
	logic [2:0]  error_code;
	logic        image_end;
	int          fail_count, pending;
	int          idle_cycles = 0;
	logic        sink_hold = 0;
	logic [7:0]  stream [$];

	always #5 clk = ~clk;

	ppm_p6_stream_parser uut (.*);

	ppm_checker chk (.*);

	// Random gap length: mostly short, sometimes long.
	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 3);
	endfunction

	// Result side stalls at random unless a stretch of full speed is on.
	initial begin
		int g;
		forever begin
			@(negedge clk);
			out_ready <= 1;
			if (!sink_hold) begin
				g = gap_len();
				repeat (g) begin
					@(negedge clk);
					out_ready <= 0;
				end
			end
		end
	end

	// Watchdog on cycles where no word moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_num(input int v);
		string s;
		s = $sformatf("%0d", v);
		foreach (s[i]) stream.push_back(s[i]);
	endtask

	task automatic add_blank();
		logic [7:0] w [4];
		w = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
		stream.push_back(w[$urandom_range(0, 3)]);
	endtask

	// Build one image: header fields with random blank runs, then pixel bytes.
	task automatic add_image(input int w, input int h, input int mx, input int bad_pct);
		int bytes_per;
		stream.push_back(CH_P);
		stream.push_back(CH_6);
		repeat ($urandom_range(1, 3)) add_blank();
		add_num(w);
		repeat ($urandom_range(1, 2)) add_blank();
		add_num(h);
		add_blank();
		add_num(mx);
		add_blank();
		bytes_per = (mx <= 255) ? 1 : 2;
		repeat (w * h * 3) begin
			int v;
			v = ($urandom_range(0, 99) < bad_pct) ? $urandom_range(0, 65535)
				: $urandom_range(0, mx);
			if ($urandom_range(0, 9) == 0) v = mx;
			if (bytes_per == 2) stream.push_back(v[15:8]);
			stream.push_back(bytes_per == 2 ? v[7:0] : (v > 255 ? 8'd255 : v[7:0]));
		end
	endtask

	// Valid drops before any gap, so a held word is never offered twice.
	task automatic send_all();
		int g;
		while (stream.size() > 0) begin
			in_valid <= 1;
			data_byte <= stream.pop_front();
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			@(negedge clk);
			g = sink_hold ? 0 : gap_len();
			if (g > 0 || stream.size() == 0)
				in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 0;
	endtask

	task automatic drain();
		while (pending > 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	initial begin
		int n;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: bad magic, extremes, errors, empty image, wide samples.
		stream = '{CH_6, CH_P, 8'hFF, 8'h00};
		add_image(1, 1, 255, 0);
		add_image(2, 1, 65535, 0);
		send_all();
		stream = '{CH_P, CH_6, CH_SPACE, 8'h41};
		stream.push_back(CH_P); stream.push_back(CH_6); stream.push_back(CH_LF);
		add_num(65536);
		stream.push_back(CH_P); stream.push_back(CH_6); stream.push_back(CH_TAB);
		add_num(0); add_blank(); add_num(5); add_blank(); add_num(9); add_blank();
		stream.push_back(CH_P); stream.push_back(CH_6); stream.push_back(CH_CR);
		add_num(1); add_blank(); add_num(1); add_blank(); add_num(0); add_blank();
		send_all();
		// Sender waits for every result before going on.
		drain();
		stream = '{CH_P, CH_6, CH_SPACE, 8'h31, CH_SPACE, 8'h31, CH_SPACE,
			8'h31, CH_SPACE, 8'h00, 8'h02, 8'h01};
		add_image(1, 1, 1, 0);
		send_all();

		// Random: mostly well-formed images, some broken ones and noise.
		n = 0;
		while (n < 1300) begin
			int start_len, mx;
			start_len = stream.size();
			case ($urandom_range(0, 9))
			0: repeat ($urandom_range(1, 8)) stream.push_back($urandom_range(0, 255));
			1: add_image($urandom_range(0, 3), $urandom_range(1, 3),
				$urandom_range(1, 300), 20);
			default: begin
				mx = ($urandom_range(0, 1)) ? $urandom_range(1, 255)
					: $urandom_range(256, 65535);
				add_image($urandom_range(1, 4), $urandom_range(1, 3), mx, 2);
			end
			endcase
			n += stream.size() - start_len;
			sink_hold = ($urandom_range(0, 7) == 0);
			send_all();
			sink_hold = 0;
		end
		// Close any image left open with one more clean header pass.
		add_image(1, 1, 255, 0);
		send_all();
		drain();
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
